// File: sv/skset_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the sorted key set.
// No dependencies; every other file but skset_ram.sv imports this package.

package skset_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef logic signed [KEY_W-1:0] key_t;

endpackage

`default_nettype wire

// File: sv/skset_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channels of the sorted key set: requests in, results out.
// Depends on skset_pkg for the field widths.

interface skset_in_if import skset_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  key_t                key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface skset_out_if import skset_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  key_t                key_out;
  logic                last;

  modport source (output valid, output status, output key_out, output last, input ready);
  modport sink   (input valid, input status, input key_out, input last, output ready);
endinterface

`default_nettype wire

// File: sv/skset_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds its value while the read enable is low. No dependencies.

module skset_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/sorted_key_set.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted key set top level: sequencer around one key memory (skset_ram).
// Depends on skset_pkg and the channel interfaces in skset_if.sv.

// The block holds up to CAPACITY distinct signed keys in ascending order in
// one RAM with one write and one read port. It takes one request at a time.
// Search, insert and delete first scan the memory from the lowest key, one
// entry per cycle, until the first key not below the requested one. Insert
// then shifts the larger keys up and delete shifts them down, one entry per
// cycle; insert then stores the new key (S_PUT) and the result is posted in
// S_EMIT. The scan and the shift together visit each stored entry once, but
// insert reads the key at the insertion point twice. List streams one key per
// cycle after the read of the lowest key while the output is not stalled.
// The result register lets the next request start while the previous result
// still waits.

module sorted_key_set import skset_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skset_in_if.sink    in_i,
  skset_out_if.source out_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [CW-1:0] OneC = CW'(1);
  localparam logic [CW-1:0] TwoC = CW'(2);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_UP   = 7'b0000100,
    S_PUT  = 7'b0001000,
    S_DOWN = 7'b0010000,
    S_EMIT = 7'b0100000,
    S_LIST = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] pos_q, pos_d;
  opcode_e       op_q, op_d;
  key_t          key_q, key_d;
  status_e       res_q, res_d;

  logic          out_valid_q, out_valid_d;
  status_e       out_status_q, out_status_d;
  key_t          out_key_q, out_key_d;
  logic          out_last_q, out_last_d;

  logic          out_free;
  logic          in_fire;
  logic          out_load;

  logic          rd_req;
  logic [CW-1:0] rd_ptr;
  logic          ram_re;
  logic          ram_we;
  logic [CW-1:0] wr_ptr;
  key_t          ram_wdata;
  logic [KEY_W-1:0] ram_rdata;
  key_t          rkey;

  logic          at_end;
  logic          key_ge;
  logic          hit;

  skset_ram #(
    .Width (KEY_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rkey     = $signed(ram_rdata);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;
  // Reads past the last entry are dropped; they only occur at the end of a scan.
  assign ram_re   = rd_req && (rd_ptr < CapC);

  assign at_end = (ptr_q == cnt_q);
  assign key_ge = !(rkey < key_q);
  assign hit    = !at_end && (rkey == key_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    pos_d        = pos_q;
    op_d         = op_q;
    key_d        = key_q;
    res_d        = res_q;
    rd_req       = 1'b0;
    rd_ptr       = '0;
    ram_we       = 1'b0;
    wr_ptr       = ptr_q;
    ram_wdata    = rkey;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d   = opcode_e'(in_i.opcode);
          key_d  = in_i.key;
          ptr_d  = '0;
          rd_req = 1'b1;
          if (opcode_e'(in_i.opcode) == OP_LIST) begin
            key_d = '0;
            if (cnt_q == '0) begin
              res_d   = ST_EMPTY;
              state_d = S_EMIT;
            end else begin
              state_d = S_LIST;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (at_end || key_ge) begin
          res_d   = ST_OK;
          state_d = S_EMIT;
          case (op_q)
            OP_SEARCH: begin
              if (cnt_q == '0) begin
                res_d = ST_EMPTY;
              end else if (!hit) begin
                res_d = ST_NOTFOUND;
              end
            end
            OP_DELETE: begin
              if (cnt_q == '0) begin
                res_d = ST_EMPTY;
              end else if (!hit) begin
                res_d = ST_NOTFOUND;
              end else if (ptr_q + OneC == cnt_q) begin
                cnt_d = cnt_q - OneC;
              end else begin
                // Pull the next key down into the freed slot.
                rd_req  = 1'b1;
                rd_ptr  = ptr_q + OneC;
                state_d = S_DOWN;
              end
            end
            OP_INSERT: begin
              pos_d = ptr_q;
              if (hit) begin
                res_d = ST_DUP;
              end else if (cnt_q == CapC) begin
                res_d = ST_FULL;
              end else if (at_end) begin
                state_d = S_PUT;
              end else begin
                // Move keys up starting from the top entry.
                rd_req  = 1'b1;
                rd_ptr  = cnt_q - OneC;
                ptr_d   = cnt_q;
                state_d = S_UP;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end else begin
          ptr_d  = ptr_q + OneC;
          rd_req = 1'b1;
          rd_ptr = ptr_q + OneC;
        end
      end

      S_UP: begin
        ram_we = 1'b1;
        if (ptr_q - OneC == pos_q) begin
          state_d = S_PUT;
        end else begin
          rd_req = 1'b1;
          rd_ptr = ptr_q - TwoC;
          ptr_d  = ptr_q - OneC;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        wr_ptr    = pos_q;
        ram_wdata = key_q;
        cnt_d     = cnt_q + OneC;
        state_d   = S_EMIT;
      end

      S_DOWN: begin
        ram_we = 1'b1;
        if (ptr_q + TwoC == cnt_q) begin
          cnt_d   = cnt_q - OneC;
          state_d = S_EMIT;
        end else begin
          rd_req = 1'b1;
          rd_ptr = ptr_q + TwoC;
          ptr_d  = ptr_q + OneC;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = res_q;
          out_key_d    = key_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_LIST: begin
        // The read data holds while the output is stalled.
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_OK;
          out_key_d    = rkey;
          out_last_d   = (ptr_q + OneC == cnt_q);
          if (ptr_q + OneC == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            rd_req = 1'b1;
            rd_ptr = ptr_q + OneC;
            ptr_d  = ptr_q + OneC;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    pos_q        <= pos_d;
    op_q         <= op_d;
    key_q        <= key_d;
    res_q        <= res_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_last_q   <= out_last_d;
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.key_out = out_key_q;
  assign out_o.last    = out_last_q;

endmodule

`default_nettype wire

// File: sim/skset_shadow_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Scoreboard for the sorted key set testbench: a shadow copy of the ordered set
// and the queue of results it predicts. Depends on skset_pkg.

package skset_shadow_pkg;
  import skset_pkg::*;

  typedef struct {
    status_e status;
    key_t    key;
    logic    last;
  } result_t;

  class sorted_set_shadow #(int unsigned CAP = 32);
    key_t        keys[CAP];
    int unsigned stored;
    result_t     awaited[$];
    int unsigned mismatches;

    function new();
      stored     = 0;
      mismatches = 0;
    endfunction

    function void post(status_e st, key_t k, logic lst);
      result_t r;
      r.status = st;
      r.key    = k;
      r.last   = lst;
      awaited.push_back(r);
    endfunction

    function key_t entry(int unsigned idx);
      return keys[idx];
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // Called once per accepted request transfer; updates the shadow set and
    // queues every result the request must produce.
    function void apply_request(opcode_e op, key_t k);
      int unsigned pos;
      bit          hit;
      if (op == OP_LIST) begin
        if (stored == 0) begin
          post(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < stored; i++) post(ST_OK, keys[i], i + 1 == stored);
        end
        return;
      end
      pos = 0;
      while (pos < stored && keys[pos] < k) pos++;
      hit = (pos < stored) && (keys[pos] == k);
      if (op == OP_INSERT) begin
        // A duplicate is reported even when the set is already full.
        if (hit) begin
          post(ST_DUP, k, 1'b1);
        end else if (stored >= CAP) begin
          post(ST_FULL, k, 1'b1);
        end else begin
          for (int unsigned i = stored; i > pos; i--) keys[i] = keys[i - 1];
          keys[pos] = k;
          stored++;
          post(ST_OK, k, 1'b1);
        end
      end else if (stored == 0) begin
        post(ST_EMPTY, k, 1'b1);
      end else if (op == OP_DELETE) begin
        if (!hit) begin
          post(ST_NOTFOUND, k, 1'b1);
        end else begin
          for (int unsigned i = pos; i + 1 < stored; i++) keys[i] = keys[i + 1];
          stored--;
          post(ST_OK, k, 1'b1);
        end
      end else begin
        post(hit ? ST_OK : ST_NOTFOUND, k, 1'b1);
      end
    endfunction

    function void match_result(logic [STATUS_W-1:0] st, key_t k, logic lst);
      result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d key %0d last %0b", st, k, lst);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status || k !== want.key || lst !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected status %0d key %0d last %0b, ",
                    "got status %0d key %0d last %0b"},
                   want.status, want.key, want.last, st, k, lst);
      end
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        $display("%0d expected results never arrived", awaited.size());
        mismatches += awaited.size();
      end
    endfunction
  endclass

endpackage

`default_nettype wire

// File: sim/tb_sorted_key_set.sv
`timescale 1ns / 1ps
`default_nettype none
// Self-checking testbench for sorted_key_set: directed and random requests,
// random idling on both channels. Depends on skset_pkg, skset_if.sv and skset_shadow_pkg.

module tb_sorted_key_set;
  import skset_pkg::*;
  import skset_shadow_pkg::*;

  localparam int unsigned CAPACITY         = 32;
  localparam int unsigned RANDOM_ITEMS     = 410;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT      = 100000;
  localparam key_t        KEY_MIN          = key_t'(32'h8000_0000);
  localparam key_t        KEY_MAX          = key_t'(32'h7fff_ffff);

  logic clk_i;
  logic rst_ni;

  skset_in_if  req_if ();
  skset_out_if rsp_if ();

  sorted_key_set #(.CAPACITY(CAPACITY)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  sorted_set_shadow #(CAPACITY) shadow;

  bit          quiet_stretch;
  bit          long_hold_req;
  int unsigned requests_sent;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(48_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int unsigned pause_cycles();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 16);
  endfunction

  function automatic opcode_e pick_op(int unsigned w_ins, int unsigned w_del,
                                      int unsigned w_srch);
    int unsigned r;
    r = $urandom_range(99);
    if (r < w_ins) return OP_INSERT;
    if (r < w_ins + w_del) return OP_DELETE;
    if (r < w_ins + w_del + w_srch) return OP_SEARCH;
    return OP_LIST;
  endfunction

  // Keys that are present, next to a present key, at the extremes, or fresh.
  function automatic key_t pick_key(int unsigned hit_pct);
    int unsigned r;
    key_t        near;
    r = $urandom_range(99);
    if (shadow.stored > 0 && r < hit_pct)
      return shadow.entry($urandom_range(shadow.stored - 1));
    if (shadow.stored > 0 && r < hit_pct + (100 - hit_pct) / 3) begin
      near = shadow.entry($urandom_range(shadow.stored - 1));
      return near + ($urandom_range(1) ? key_t'(1) : key_t'(-1));
    end
    if (r >= 97) return r[0] ? KEY_MAX : KEY_MIN;
    return key_t'($urandom);
  endfunction

  task automatic issue(opcode_e op, key_t k);
    int unsigned gap;
    gap = quiet_stretch ? 0 : pause_cycles();
    if (gap > 0) begin
      // Junk on the payload while valid is low must be ignored.
      req_if.valid  <= 1'b0;
      req_if.opcode <= 2'($urandom_range(3));
      req_if.key    <= key_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.key    <= k;
    do @(posedge clk_i); while (!req_if.ready);
    shadow.apply_request(op, k);
    requests_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      shadow.match_result(rsp_if.status, rsp_if.key_out, rsp_if.last);
  end

  initial begin : result_ready_driver
    int unsigned stall;
    int unsigned n;
    stall = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        // Long hold-off so that the block fills up and stalls its input.
        long_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        n = quiet_stretch ? 0 : pause_cycles();
        if (n > 0) begin
          stall = n - 1;
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned random_base;
    int unsigned guard;
    int unsigned phase;
    bit          first_phase;
    bit          hold_done;

    shadow        = new();
    quiet_stretch = 1'b0;
    long_hold_req = 1'b0;
    requests_sent = 0;
    rst_ni        = 1'b0;
    req_if.valid  <= 1'b0;
    req_if.opcode <= OP_INSERT;
    req_if.key    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty set, extremes of the key range, signed ordering, duplicates.
    issue(OP_SEARCH, key_t'(5));
    issue(OP_DELETE, key_t'(7));
    issue(OP_LIST, key_t'(32'hdead_beef));
    issue(OP_INSERT, key_t'(0));
    issue(OP_INSERT, KEY_MAX);
    issue(OP_INSERT, KEY_MIN);
    issue(OP_INSERT, key_t'(-1));
    issue(OP_INSERT, key_t'(1));
    issue(OP_INSERT, key_t'(0));
    issue(OP_LIST, '0);
    issue(OP_SEARCH, KEY_MIN);
    issue(OP_SEARCH, KEY_MAX);
    issue(OP_SEARCH, key_t'(2));
    issue(OP_DELETE, key_t'(-1));
    issue(OP_DELETE, key_t'(-1));
    issue(OP_DELETE, KEY_MAX);
    issue(OP_DELETE, KEY_MIN);
    issue(OP_INSERT, key_t'(32'h5555_5555));
    issue(OP_INSERT, key_t'(32'haaaa_aaaa));
    issue(OP_LIST, key_t'(32'hffff_ffff));
    issue(OP_DELETE, key_t'(0));
    issue(OP_DELETE, key_t'(1));
    issue(OP_DELETE, key_t'(32'h5555_5555));
    issue(OP_DELETE, key_t'(32'haaaa_aaaa));
    issue(OP_LIST, '0);

    random_base = requests_sent;
    first_phase = 1'b1;
    hold_done   = 1'b0;
    while (requests_sent - random_base < RANDOM_ITEMS) begin
      if (!hold_done && requests_sent - random_base >= 150) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      phase         = first_phase ? 0 : $urandom_range(3);
      quiet_stretch = ($urandom_range(3) == 0);
      case (phase)
        0: begin
          while (shadow.stored < CAPACITY) issue(OP_INSERT, pick_key(10));
          issue(OP_INSERT, pick_key(100));
          issue(OP_INSERT, key_t'($urandom));
          issue(OP_SEARCH, pick_key(50));
          issue(OP_LIST, key_t'($urandom));
        end
        1: begin
          while (shadow.stored > 0) issue(pick_op(10, 70, 15), pick_key(75));
          issue(OP_DELETE, key_t'($urandom));
          issue(OP_SEARCH, key_t'($urandom));
          issue(OP_LIST, key_t'($urandom));
        end
        2: begin
          repeat (30) issue(pick_op(35, 25, 30), pick_key(50));
        end
        default: begin
          repeat (12) issue(pick_op(20, 20, 30), pick_key(60));
        end
      endcase
      first_phase = 1'b0;
    end

    quiet_stretch = 1'b0;
    req_if.valid <= 1'b0;
    guard = 0;
    while (shadow.outstanding() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * CAPACITY + 8) @(posedge clk_i);
    shadow.close_out();
    if (shadow.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
